/* sv/gblur5_pkg.sv */
package gblur5_pkg;

    localparam int CHANNELS    = 3;
    localparam int PIXEL_BITS  = 8;
    localparam int TAPS        = 5;
    localparam int NUM_BANKS   = 8;
    localparam int BANK_W      = 3;
    localparam int ROW_W       = 13;
    localparam int HGT_W       = 12;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int WGT_W       = 16;
    localparam int NUM_WEIGHTS = 6;
    localparam int FRAC        = 16;
    localparam int FIFO_DEPTH  = 16;
    localparam int FIFO_AW     = 4;
    localparam int PROD_W      = PIXEL_BITS + WGT_W;
    localparam int CSUM_W      = PROD_W + 3;
    localparam int TOT_W       = CSUM_W + 3;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT1 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT2 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT4 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT5 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT8 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 4'd7;

    localparam logic [WGT_W-1:0] WEIGHT_RESET [NUM_WEIGHTS] =
        '{16'd10625, 16'd6443, 16'd3908, 16'd1437, 16'd874, 16'd195};
    localparam logic [HGT_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [HGT_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [PIXEL_BITS-1:0] PIX_MAX = {PIXEL_BITS{1'b1}};

    typedef logic [PIXEL_BITS-1:0] chan_t;
    typedef chan_t [CHANNELS-1:0] pix_t;
    typedef pix_t [TAPS-1:0] col_t;
    typedef logic [WGT_W-1:0] wgt_t;
    typedef wgt_t [TAPS-1:0] col_wgt_t;
    typedef logic [CSUM_W-1:0] csum_t;
    typedef csum_t [CHANNELS-1:0] csum_vec_t;
    typedef logic [BANK_W-1:0] bank_t;

    typedef struct packed {
        logic step;
        logic load;
    } cell_ctl_t;

    typedef struct packed {
        logic frame_end;
        pix_t chans;
    } result_t;

    // squared tap distance -> weight register
    function automatic int dist_class(input int sq);
        int cls;
        unique case (sq)
            0:       cls = 0;
            1:       cls = 1;
            2:       cls = 2;
            4:       cls = 3;
            5:       cls = 4;
            8:       cls = 5;
            default: cls = 0;
        endcase
        return cls;
    endfunction

    // line bank holding row base+dy, clamped to the frame
    function automatic bank_t tap_bank(input logic [ROW_W-1:0] base,
                                       input logic [ROW_W-1:0] hmax,
                                       input int dy);
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] off;
        if (dy < 0) begin
            off = ROW_W'(-dy);
            row = (base >= off) ? base - off : '0;
        end else begin
            off = ROW_W'(dy);
            row = (base + off > hmax) ? hmax : base + off;
        end
        return row[BANK_W-1:0];
    endfunction

endpackage

/* sv/gblur5_ram.sv */
module gblur5_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

/* sv/gblur5_cell.sv */
module gblur5_cell (
    input  logic                  aclk,
    input  gblur5_pkg::cell_ctl_t ctl,
    input  gblur5_pkg::col_t      load_col,
    input  gblur5_pkg::col_t      prev_col,
    input  gblur5_pkg::col_wgt_t  wgt,
    output gblur5_pkg::col_t      col_out,
    output gblur5_pkg::csum_vec_t csum
);
    import gblur5_pkg::*;

    col_t                    col_reg;
    logic [PROD_W-1:0]       prod_reg [TAPS][CHANNELS];
    csum_vec_t               csum_reg;
    csum_vec_t               csum_next;

    // one window column: shift from the left neighbor, or reload at row start
    always_ff @(posedge aclk) begin
        if (ctl.step) begin
            col_reg <= ctl.load ? load_col : prev_col;
        end
    end

    always_ff @(posedge aclk) begin
        for (int t = 0; t < TAPS; t++) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                prod_reg[t][ch] <= PROD_W'(col_reg[t][ch]) * PROD_W'(wgt[t]);
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            csum_next[ch] = '0;
            for (int t = 0; t < TAPS; t++) begin
                csum_next[ch] = csum_next[ch] + CSUM_W'(prod_reg[t][ch]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        csum_reg <= csum_next;
    end

    assign col_out = col_reg;
    assign csum    = csum_reg;

endmodule

/* sv/gaussian_blur_5x5.sv */
// 5x5 Gaussian blur over a raster pixel stream, three 8-bit channels, with
// clamp-to-edge borders. Takes one item per clock and gives one result per
// clock in steady state, unless s_ready or m_ready holds it back. The result
// for output pixel m is returned for the item at frame position m+2*W+2, so
// 2*W+2 drain items must follow the W*H pixels of a frame; the last result
// carries frame_end and the next item starts a new frame. Results pass the
// fetch, window, product and sum registers into a 16-entry output queue;
// input ready drops only when that queue plus the results in flight would be
// full. Rows are kept in eight line banks of MAX_WIDTH pixels, each with two
// read ports; the window is a chain of five column cells that multiply and
// sum their taps. Weights and frame size are to be written through the cfg port
// while the block is idle, which it does not enforce; a width or height write restarts the frame.
module gaussian_blur_5x5 #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_op,
    input  logic [gblur5_pkg::PIXEL_BITS-1:0]    s_in_chan0,
    input  logic [gblur5_pkg::PIXEL_BITS-1:0]    s_in_chan1,
    input  logic [gblur5_pkg::PIXEL_BITS-1:0]    s_in_chan2,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [gblur5_pkg::PIXEL_BITS-1:0]    m_out_chan0,
    output logic [gblur5_pkg::PIXEL_BITS-1:0]    m_out_chan1,
    output logic [gblur5_pkg::PIXEL_BITS-1:0]    m_out_chan2,
    output logic                                 m_frame_end,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gblur5_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gblur5_pkg::CFG_W-1:0]         cfg_data
);
    import gblur5_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int LAG_W = WW + 2;
    localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);

    // ---------------- configuration ----------------
    wgt_t             weight_reg [NUM_WEIGHTS];
    logic [HGT_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    logic             cfg_wr;
    logic             restart;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign restart   = cfg_wr && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_WEIGHTS; i++) begin
                weight_reg[i] <= WEIGHT_RESET[i];
            end
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                REG_WEIGHT0: weight_reg[0] <= cfg_data;
                REG_WEIGHT1: weight_reg[1] <= cfg_data;
                REG_WEIGHT2: weight_reg[2] <= cfg_data;
                REG_WEIGHT4: weight_reg[3] <= cfg_data;
                REG_WEIGHT5: weight_reg[4] <= cfg_data;
                REG_WEIGHT8: weight_reg[5] <= cfg_data;
                REG_WIDTH:   width_reg     <= cfg_data[HGT_W-1:0];
                REG_HEIGHT:  height_reg    <= cfg_data[HGT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [WW-1:0]    w_eff;
    logic [WW-1:0]    wm1;
    logic [HGT_W-1:0] h_eff;
    logic [ROW_W-1:0] hm1;
    logic [LAG_W-1:0] lag;
    logic             w_ge2;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = MAXW;
        end else begin
            w_eff = WW'(width_reg);
        end
    end

    assign h_eff = (height_reg == '0) ? HGT_W'(1) : height_reg;
    assign wm1   = w_eff - WW'(1);
    assign hm1   = ROW_W'(h_eff) - ROW_W'(1);
    assign lag   = LAG_W'({w_eff, 1'b0}) + LAG_W'(2);
    assign w_ge2 = (w_eff != WW'(1));

    // ---------------- position counters ----------------
    logic [COL_W-1:0] in_col_reg;
    logic [ROW_W-1:0] in_row_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [HGT_W-1:0] out_row_reg;
    logic [LAG_W-1:0] pre_cnt_reg;
    logic             accept;
    logic             out_go;
    logic             out_col_end;
    logic             in_col_end;
    logic             is_last;
    logic             store;

    assign accept      = s_valid && s_ready;
    assign out_go      = (pre_cnt_reg == lag);
    assign out_col_end = (WW'(out_col_reg) == wm1);
    assign in_col_end  = (WW'(in_col_reg) == wm1);
    assign is_last     = out_go && out_col_end && (ROW_W'(out_row_reg) == hm1);
    assign store       = (in_row_reg < ROW_W'(h_eff));

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pre_cnt_reg <= '0;
        end else if (accept) begin
            if (is_last) begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
                pre_cnt_reg <= '0;
            end else begin
                if (out_go) begin
                    if (out_col_end) begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + HGT_W'(1);
                    end else begin
                        out_col_reg <= out_col_reg + COL_W'(1);
                    end
                end else begin
                    pre_cnt_reg <= pre_cnt_reg + LAG_W'(1);
                end
                if (in_col_end) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + ROW_W'(1);
                end else begin
                    in_col_col_inc: begin
                        in_col_reg <= in_col_reg + COL_W'(1);
                    end
                end
            end
        end
    end

    // ---------------- job for the window ----------------
    // port A fetches the column entering the window, port B fetches columns
    // 0 and 1 of the next row block during the last two steps of a row
    logic             job_b0;
    logic             job_b1;
    logic [WW:0]      c_plus2;
    logic [COL_W-1:0] xa_next;
    logic [COL_W-1:0] xb_next;
    logic [ROW_W-1:0] nb_row;
    bank_t            bank_a_next [TAPS];
    bank_t            bank_b_next [TAPS];

    always_comb begin
        if (out_go) begin
            job_b0 = w_ge2 ? (WW'(out_col_reg) == w_eff - WW'(2)) : out_col_end;
            job_b1 = out_col_end;
        end else begin
            job_b0 = w_ge2 ? (pre_cnt_reg == lag - LAG_W'(2)) : (pre_cnt_reg == lag - LAG_W'(1));
            job_b1 = (pre_cnt_reg == lag - LAG_W'(1));
        end
        c_plus2 = (WW + 1)'(out_col_reg) + (WW + 1)'(2);
        xa_next = (c_plus2 > (WW + 1)'(wm1)) ? COL_W'(wm1) : COL_W'(c_plus2);
        xb_next = (job_b1 && !job_b0) ? COL_W'(1) : '0;
        nb_row  = out_go ? ROW_W'(out_row_reg) + ROW_W'(1) : '0;
        for (int t = 0; t < TAPS; t++) begin
            bank_a_next[t] = tap_bank(ROW_W'(out_row_reg), hm1, t - 2);
            bank_b_next[t] = tap_bank(nb_row, hm1, t - 2);
        end
    end

    logic             s1_real_reg, s1_b0_reg, s1_b1_reg;
    logic             s1_load_reg, s1_last_reg;
    logic [COL_W-1:0] s1_xa_reg, s1_xb_reg;
    bank_t            s1_bank_a_reg [TAPS];
    bank_t            s1_bank_b_reg [TAPS];
    logic             s2_real_reg, s2_b0_reg, s2_b1_reg;
    logic             s2_load_reg, s2_last_reg;
    bank_t            s2_bank_a_reg [TAPS];
    bank_t            s2_bank_b_reg [TAPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_real_reg <= 1'b0;
            s1_b0_reg   <= 1'b0;
            s1_b1_reg   <= 1'b0;
            s2_real_reg <= 1'b0;
            s2_b0_reg   <= 1'b0;
            s2_b1_reg   <= 1'b0;
        end else begin
            s1_real_reg <= accept && out_go;
            s1_b0_reg   <= accept && job_b0;
            s1_b1_reg   <= accept && job_b1;
            s2_real_reg <= s1_real_reg;
            s2_b0_reg   <= s1_b0_reg;
            s2_b1_reg   <= s1_b1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_load_reg <= (out_col_reg == '0);
            s1_last_reg <= is_last;
            s1_xa_reg   <= xa_next;
            s1_xb_reg   <= xb_next;
            s1_bank_a_reg <= bank_a_next;
            s1_bank_b_reg <= bank_b_next;
        end
        s2_load_reg   <= s1_load_reg;
        s2_last_reg   <= s1_last_reg;
        s2_bank_a_reg <= s1_bank_a_reg;
        s2_bank_b_reg <= s1_bank_b_reg;
    end

    // ---------------- line banks ----------------
    pix_t in_pix;
    pix_t rd_a [NUM_BANKS];
    pix_t rd_b [NUM_BANKS];

    assign in_pix = {s_in_chan2, s_in_chan1, s_in_chan0};

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        gblur5_ram #(
            .WIDTH ($bits(pix_t)),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .aclk      (aclk),
            .wr_en     (accept && store && (in_row_reg[BANK_W-1:0] == BANK_W'(b))),
            .wr_addr   (in_col_reg),
            .wr_data   (in_pix),
            .rd_addr_a (s1_xa_reg),
            .rd_data_a (rd_a[b]),
            .rd_addr_b (s1_xb_reg),
            .rd_data_b (rd_b[b])
        );
    end

    col_t col_a;
    col_t col_b;
    col_t p0_reg;
    col_t p1_reg;

    always_comb begin
        for (int t = 0; t < TAPS; t++) begin
            col_a[t] = rd_a[s2_bank_a_reg[t]];
            col_b[t] = rd_b[s2_bank_b_reg[t]];
        end
    end

    // columns 0 and 1 of the coming row, held for the row-start reload
    always_ff @(posedge aclk) begin
        if (s2_b0_reg) begin
            p0_reg <= col_b;
        end
        if (s2_b1_reg) begin
            p1_reg <= col_b;
        end
    end

    // ---------------- window cells ----------------
    cell_ctl_t cell_ctl;
    col_t      cell_col  [TAPS];
    csum_vec_t cell_csum [TAPS];

    assign cell_ctl.step = s2_real_reg;
    assign cell_ctl.load = s2_load_reg;

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        localparam int DX = (k > 2) ? k - 2 : 2 - k;
        col_wgt_t cw;
        col_t     load_src;
        col_t     prev_src;

        for (genvar t = 0; t < TAPS; t++) begin : g_wgt
            localparam int DY = (t > 2) ? t - 2 : 2 - t;
            assign cw[t] = weight_reg[dist_class(DX * DX + DY * DY)];
        end

        if (k == 0) begin : g_first
            assign load_src = col_a;
            assign prev_src = col_a;
        end else if (k == 1) begin : g_second
            assign load_src = p1_reg;
            assign prev_src = cell_col[k-1];
        end else begin : g_rest
            assign load_src = p0_reg;
            assign prev_src = cell_col[k-1];
        end

        gblur5_cell u_cell (
            .aclk     (aclk),
            .ctl      (cell_ctl),
            .load_col (load_src),
            .prev_col (prev_src),
            .wgt      (cw),
            .col_out  (cell_col[k]),
            .csum     (cell_csum[k])
        );
    end

    // ---------------- sum, clamp, output queue ----------------
    logic             win_valid_reg, prod_valid_reg, csum_valid_reg, tot_valid_reg;
    logic             win_last_reg, prod_last_reg, csum_last_reg, tot_last_reg;
    logic [TOT_W-1:0] tot_reg  [CHANNELS];
    logic [TOT_W-1:0] tot_next [CHANNELS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            csum_valid_reg <= 1'b0;
            tot_valid_reg  <= 1'b0;
        end else begin
            win_valid_reg  <= s2_real_reg;
            prod_valid_reg <= win_valid_reg;
            csum_valid_reg <= prod_valid_reg;
            tot_valid_reg  <= csum_valid_reg;
        end
    end

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            tot_next[ch] = '0;
            for (int k = 0; k < TAPS; k++) begin
                tot_next[ch] = tot_next[ch] + TOT_W'(cell_csum[k][ch]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_real_reg) begin
            win_last_reg <= s2_last_reg;
        end
        prod_last_reg <= win_last_reg;
        csum_last_reg <= prod_last_reg;
        tot_last_reg  <= csum_last_reg;
        tot_reg       <= tot_next;
    end

    result_t res;
    logic [TOT_W-FRAC-1:0] shifted [CHANNELS];

    always_comb begin
        res.frame_end = tot_last_reg;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            shifted[ch] = tot_reg[ch][TOT_W-1:FRAC];
            res.chans[ch] = (shifted[ch] > (TOT_W - FRAC)'(PIX_MAX)) ? PIX_MAX
                            : shifted[ch][PIXEL_BITS-1:0];
        end
    end

    result_t            fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   fifo_cnt_reg;
    logic [FIFO_AW:0]   credit_reg;
    logic               pop;
    logic               take;
    result_t            head;

    assign pop  = m_valid && m_ready;
    assign take = accept && out_go;

    always_ff @(posedge aclk) begin
        if (tot_valid_reg) begin
            fifo_mem[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            credit_reg   <= '0;
        end else begin
            if (tot_valid_reg) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + (FIFO_AW + 1)'(tot_valid_reg)
                            - (FIFO_AW + 1)'(pop);
            credit_reg   <= credit_reg + (FIFO_AW + 1)'(take) - (FIFO_AW + 1)'(pop);
        end
    end

    // credit covers results in flight plus queued ones
    assign s_ready     = (credit_reg < (FIFO_AW + 1)'(FIFO_DEPTH));
    assign m_valid     = (fifo_cnt_reg != '0);
    assign head        = fifo_mem[rd_ptr_reg];
    assign m_out_chan0 = head.chans[0];
    assign m_out_chan1 = head.chans[1];
    assign m_out_chan2 = head.chans[2];
    assign m_frame_end = head.frame_end;

    // ---------------- assertions ----------------
    a_queue_within_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt_reg <= credit_reg)
        else $error("output queue holds more than the issued credit");

    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_reg <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("credit count above queue depth");

    a_out_col_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        WW'(out_col_reg) < w_eff)
        else $error("output column beyond frame width");

    a_step_needs_job: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_real_reg |-> $past(s1_real_reg))
        else $error("window step without a fetched column");

endmodule

/* bench/tb_gaussian_blur_5x5.sv */
module tb_gaussian_blur_5x5;
    import gblur5_pkg::*;

    localparam int RING_DEPTH  = 4 * 2048 + 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 400;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic  frame_end;
        chan_t c2;
        chan_t c1;
        chan_t c0;
    } blur_px_t;

    class blur_scoreboard;
        logic [15:0] regs [8];
        logic [23:0] ring [RING_DEPTH];
        int unsigned in_col, in_row, out_col, out_row;
        blur_px_t    expected_px [$];
        int          errors;

        function new();
            regs[REG_WEIGHT0] = WEIGHT_RESET[0];
            regs[REG_WEIGHT1] = WEIGHT_RESET[1];
            regs[REG_WEIGHT2] = WEIGHT_RESET[2];
            regs[REG_WEIGHT4] = WEIGHT_RESET[3];
            regs[REG_WEIGHT5] = WEIGHT_RESET[4];
            regs[REG_WEIGHT8] = WEIGHT_RESET[5];
            regs[REG_WIDTH]   = 16'(WIDTH_RESET);
            regs[REG_HEIGHT]  = 16'(HEIGHT_RESET);
            foreach (ring[i]) ring[i] = '0;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            errors = 0;
        endfunction

        function int unsigned eff_w();
            int unsigned w;
            w = regs[REG_WIDTH];
            if (w == 0) w = 1;
            if (w > 2048) w = 2048;
            return w;
        endfunction

        function int unsigned eff_h();
            return (regs[REG_HEIGHT] == 0) ? 1 : regs[REG_HEIGHT];
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx > REG_HEIGHT) return;
            regs[idx] = (idx >= REG_WIDTH) ? (val & 16'h0fff) : val;
            if (idx >= REG_WIDTH) begin
                in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            end
        endfunction

        function int unsigned tap_weight(int sq);
            case (sq)
                0: return regs[REG_WEIGHT0];
                1: return regs[REG_WEIGHT1];
                2: return regs[REG_WEIGHT2];
                4: return regs[REG_WEIGHT4];
                5: return regs[REG_WEIGHT5];
                default: return regs[REG_WEIGHT8];
            endcase
        endfunction

        function void note_pixel(chan_t c0, chan_t c1, chan_t c2);
            int unsigned w, h, n, a;
            int          y, x;
            longint unsigned acc [3];
            blur_px_t    px;
            logic [23:0] tap;
            w = eff_w();
            h = eff_h();
            n = in_row * w + in_col;
            if (n < w * h) ring[n % RING_DEPTH] = {c2, c1, c0};
            if (n >= 2 * w + 2) begin
                acc[0] = 0; acc[1] = 0; acc[2] = 0;
                for (int dy = -2; dy <= 2; dy++) begin
                    for (int dx = -2; dx <= 2; dx++) begin
                        y = int'(out_row) + dy;
                        x = int'(out_col) + dx;
                        if (y < 0) y = 0;
                        if (y > int'(h) - 1) y = h - 1;
                        if (x < 0) x = 0;
                        if (x > int'(w) - 1) x = w - 1;
                        a = (y * w + x) % RING_DEPTH;
                        tap = ring[a];
                        for (int ch = 0; ch < 3; ch++)
                            acc[ch] += tap[8*ch +: 8] * tap_weight(dy*dy + dx*dx);
                    end
                end
                for (int ch = 0; ch < 3; ch++) begin
                    acc[ch] = acc[ch] >> FRAC;
                    if (acc[ch] > 255) acc[ch] = 255;
                end
                px.c0 = acc[0][7:0];
                px.c1 = acc[1][7:0];
                px.c2 = acc[2][7:0];
                px.frame_end = (out_row == h - 1) && (out_col == w - 1);
                expected_px.insert(expected_px.size(), px);
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row++;
                end
                if (px.frame_end) begin
                    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
                    return;
                end
            end
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        endfunction

        function void check_px(blur_px_t got);
            blur_px_t exp_px;
            if (expected_px.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            exp_px = expected_px.pop_front();
            if (got.c0 !== exp_px.c0 || got.c1 !== exp_px.c1 || got.c2 !== exp_px.c2 ||
                got.frame_end !== exp_px.frame_end) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp c0=%0d c1=%0d c2=%0d fe=%0d got c0=%0d c1=%0d c2=%0d fe=%0d",
                             exp_px.c0, exp_px.c1, exp_px.c2, exp_px.frame_end,
                             got.c0, got.c1, got.c2, got.frame_end);
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0, s_ready, s_op = 1'b0;
    chan_t s_in_chan0 = '0, s_in_chan1 = '0, s_in_chan2 = '0;
    logic m_valid, m_ready = 1'b0, m_frame_end;
    chan_t m_out_chan0, m_out_chan1, m_out_chan2;
    logic cfg_valid = 1'b0, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    blur_scoreboard sb = new();
    int  burst_left = 0;
    int  items_sent = 0;
    int  cycles = 0;
    bit  hold_req = 0;
    int  hold_cnt = 0;
    int  rx_mode = 0;

    gaussian_blur_5x5 u_dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        if (aresetn && m_valid && m_ready)
            sb.check_px({m_frame_end, m_out_chan2, m_out_chan1, m_out_chan0});
    end

    // receiver stall pattern, with an occasional long hold-off
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_cnt = LONG_HOLD;
        end
        if (cycles % 64 == 0) rx_mode = $urandom_range(0, 2);
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                default: m_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    task automatic send_item(logic op, chan_t c0, chan_t c1, chan_t c2);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 60);
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_op <= op;
        s_in_chan0 <= c0;
        s_in_chan1 <= c1;
        s_in_chan2 <= c2;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(c0, c1, c2);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_px.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_size(int w12, int h12);
        write_cfg(REG_WIDTH, {4'($urandom), 12'(w12)});
        write_cfg(REG_HEIGHT, {4'($urandom), 12'(h12)});
    endtask

    function automatic chan_t rnd_chan();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // pixels, then drain; cut > 0 stops the frame early
    task automatic send_frame(int cut, bit directed);
        int unsigned w, h, total;
        logic op;
        w = sb.eff_w();
        h = sb.eff_h();
        total = w * h + 2 * w + 2;
        if (cut > 0 && cut < total) total = cut;
        for (int unsigned i = 0; i < total; i++) begin
            if (i < w * h) op = ($urandom_range(0, 9) == 0) ? OP_DRAIN : OP_PIXEL;
            else op = ($urandom_range(0, 9) == 0) ? OP_PIXEL : OP_DRAIN;
            if (directed) send_item(op, (i % 2) ? 8'd255 : 8'd0, (i % 3) ? 8'd0 : 8'd255,
                                    8'd255 - 8'(i));
            else send_item(op, rnd_chan(), rnd_chan(), rnd_chan());
        end
    endtask

    function automatic logic [15:0] rnd_weight();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hffff;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 5000));
        endcase
    endfunction

    initial begin
        int phase;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(posedge aclk);

        // directed: tiny frames, zero size, saturating and zero weights
        set_size(0, 0);
        send_frame(0, 1);
        wait_drained();
        for (int i = REG_WEIGHT0; i <= REG_WEIGHT8; i++) write_cfg(CFG_IDX_W'(i), 16'hffff);
        set_size(2, 2);
        send_frame(0, 1);
        wait_drained();
        for (int i = REG_WEIGHT0; i <= REG_WEIGHT8; i++) write_cfg(CFG_IDX_W'(i), 16'h0000);
        write_cfg(4'hf, 16'h1234);
        set_size(1, 1);
        send_frame(0, 1);
        wait_drained();

        phase = 0;
        while (items_sent < 1240) begin
            for (int i = REG_WEIGHT0; i <= REG_WEIGHT8; i++)
                if ($urandom_range(0, 2) != 0) write_cfg(CFG_IDX_W'(i), rnd_weight());
            if ($urandom_range(0, 7) == 0) write_cfg(4'($urandom_range(8, 15)), 16'($urandom));
            set_size($urandom_range(1, 12), $urandom_range(1, 8));
            if (phase == 3) hold_req = 1;
            for (int f = $urandom_range(1, 3); f > 0; f--) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_frame($urandom_range(1, 40), 0);
                    break;
                end
                send_frame(0, 0);
                if (phase == 5) wait_drained();
            end
            wait_drained();
            phase++;
        end

        // widest and tallest frames, cut short
        set_size(12'd4095, 1);
        send_frame(64, 0);
        wait_drained();
        set_size(1, 12'd4095);
        send_frame(300, 0);
        wait_drained();

        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_px.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

/* gaussian_blur_5x5.f */
sv/gblur5_pkg.sv
sv/gblur5_ram.sv
sv/gblur5_cell.sv
sv/gaussian_blur_5x5.sv
bench/tb_gaussian_blur_5x5.sv
